// ===== src/ipv4rhf_pkg.sv =====
package ipv4rhf_pkg;

  // verdict codes carried in out_tuser
  typedef enum logic [3:0] {
    VERDICT_ICMP        = 4'd0,
    VERDICT_UDP         = 4'd1,
    VERDICT_TCP         = 4'd2,
    VERDICT_UNKNOWN     = 4'd3,
    VERDICT_SHORT       = 4'd4,
    VERDICT_VERSION     = 4'd5,
    VERDICT_HDR_LEN     = 4'd6,
    VERDICT_CHECKSUM    = 4'd7,
    VERDICT_TOTAL_LEN   = 4'd8,
    VERDICT_ADDRESS     = 4'd9
  } verdict_t;

  // header constants
  localparam logic [15:0] HDR_MIN        = 16'd20;
  localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;
  localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [3:0]  IP_VERSION     = 4'd4;

  // protocol numbers
  localparam logic [7:0] PROTOCOL_ICMP = 8'd1;
  localparam logic [7:0] PROTOCOL_TCP  = 8'd6;
  localparam logic [7:0] PROTOCOL_UDP  = 8'd17;

  // byte positions inside the header
  localparam logic [15:0] IDX_VER_IHL  = 16'd0;
  localparam logic [15:0] IDX_TLEN_HI  = 16'd2;
  localparam logic [15:0] IDX_TLEN_LO  = 16'd3;
  localparam logic [15:0] IDX_PROTO    = 16'd9;
  localparam logic [15:0] IDX_SRC_LO   = 16'd12;
  localparam logic [15:0] IDX_SRC_HI   = 16'd15;
  localparam logic [15:0] IDX_DST_LO   = 16'd16;
  localparam logic [15:0] IDX_DST_HI   = 16'd19;

  // snapshot of a finished packet handed to the verdict stage
  typedef struct packed {
    logic [15:0] pkt_len;
    logic [7:0]  ver_ihl;
    logic [15:0] total_len;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] hdr_sum;
  } hdr_snap_t;

endpackage

// ===== src/ipv4rhf_parser.sv =====
module ipv4rhf_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  logic [7:0]             pkt_byte,
  input  logic                   pkt_last,
  output logic                   snap_valid,
  input  logic                   snap_ready,
  output ipv4rhf_pkg::hdr_snap_t snap
);

  logic [15:0] count_r, count_nxt;
  logic [7:0]  ver_ihl_r, ver_ihl_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        snap_valid_r, snap_valid_nxt;
  ipv4rhf_pkg::hdr_snap_t snap_r, snap_nxt;

  logic        accept;
  logic [15:0] hbytes;
  logic [16:0] word_sum;

  // a byte can enter unless a finished snapshot is stuck
  assign byte_ready = !snap_valid_r || snap_ready;
  assign accept     = byte_valid && byte_ready;

  // header field capture and ones' complement accumulation
  always_comb begin
    ver_ihl_nxt = (count_r == ipv4rhf_pkg::IDX_VER_IHL) ? pkt_byte : ver_ihl_r;
    hbytes      = {10'd0, ver_ihl_nxt[3:0], 2'b00};
    tlen_nxt    = tlen_r;
    proto_nxt   = proto_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    sum_nxt     = sum_r;
    hold_nxt    = hold_r;
    word_sum    = {1'b0, sum_r} + {1'b0, hold_r, pkt_byte};

    if (count_r < hbytes) begin
      if (count_r[0]) begin
        sum_nxt = word_sum[15:0] + {15'd0, word_sum[16]};
      end else begin
        hold_nxt = pkt_byte;
      end
    end

    if (count_r == ipv4rhf_pkg::IDX_TLEN_HI || count_r == ipv4rhf_pkg::IDX_TLEN_LO) begin
      tlen_nxt = {tlen_r[7:0], pkt_byte};
    end else if (count_r == ipv4rhf_pkg::IDX_PROTO) begin
      proto_nxt = pkt_byte;
    end else if (count_r >= ipv4rhf_pkg::IDX_SRC_LO && count_r <= ipv4rhf_pkg::IDX_SRC_HI) begin
      src_nxt = {src_r[23:0], pkt_byte};
    end else if (count_r >= ipv4rhf_pkg::IDX_DST_LO && count_r <= ipv4rhf_pkg::IDX_DST_HI) begin
      dst_nxt = {dst_r[23:0], pkt_byte};
    end

    // saturating byte counter
    count_nxt = (count_r < ipv4rhf_pkg::COUNT_MAX) ? count_r + 16'd1 : count_r;

    snap_nxt.pkt_len   = count_nxt;
    snap_nxt.ver_ihl   = ver_ihl_nxt;
    snap_nxt.total_len = tlen_nxt;
    snap_nxt.protocol  = proto_nxt;
    snap_nxt.src_addr  = src_nxt;
    snap_nxt.dst_addr  = dst_nxt;
    snap_nxt.hdr_sum   = sum_nxt;

    // handoff slot to the verdict stage
    if (accept && pkt_last) begin
      snap_valid_nxt = 1'b1;
    end else if (snap_ready) begin
      snap_valid_nxt = 1'b0;
    end else begin
      snap_valid_nxt = snap_valid_r;
    end
  end

  // per-packet state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ver_ihl_r <= '0;
      tlen_r    <= '0;
      proto_r   <= '0;
      src_r     <= '0;
      dst_r     <= '0;
      sum_r     <= '0;
      hold_r    <= '0;
    end else if (accept) begin
      if (pkt_last) begin
        count_r   <= '0;
        ver_ihl_r <= '0;
        tlen_r    <= '0;
        proto_r   <= '0;
        src_r     <= '0;
        dst_r     <= '0;
        sum_r     <= '0;
        hold_r    <= '0;
      end else begin
        count_r   <= count_nxt;
        ver_ihl_r <= ver_ihl_nxt;
        tlen_r    <= tlen_nxt;
        proto_r   <= proto_nxt;
        src_r     <= src_nxt;
        dst_r     <= dst_nxt;
        sum_r     <= sum_nxt;
        hold_r    <= hold_nxt;
      end
    end
  end

  // snapshot register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pkt_last) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

// ===== src/ipv4rhf_verdict.sv =====
module ipv4rhf_verdict (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            local_addr,
  input  logic                   snap_valid,
  output logic                   snap_ready,
  input  ipv4rhf_pkg::hdr_snap_t snap,
  output logic                   res_valid,
  input  logic                   res_ready,
  output ipv4rhf_pkg::verdict_t  res_verdict,
  output logic [31:0]            res_src,
  output logic [31:0]            res_dst,
  output logic [5:0]             res_hdr_bytes,
  output logic [15:0]            res_payload_len
);

  logic                  valid_r, valid_nxt;
  ipv4rhf_pkg::verdict_t verdict_r, verdict_nxt;
  logic [31:0]           src_r, dst_r;
  logic [5:0]            hbytes_r, hbytes_nxt;
  logic [15:0]           payload_r, payload_nxt;
  logic [15:0]           hbytes_w;
  logic                  load;

  assign snap_ready = !valid_r || res_ready;
  assign load       = snap_valid && snap_ready;

  // checks in priority order, then protocol routing
  always_comb begin
    hbytes_nxt  = {snap.ver_ihl[3:0], 2'b00};
    hbytes_w    = {10'd0, hbytes_nxt};
    payload_nxt = snap.total_len - hbytes_w;

    priority if (snap.pkt_len < ipv4rhf_pkg::HDR_MIN) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_SHORT;
    end else if (snap.ver_ihl[7:4] != ipv4rhf_pkg::IP_VERSION) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_VERSION;
    end else if (hbytes_w < ipv4rhf_pkg::HDR_MIN || hbytes_w > snap.pkt_len) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_HDR_LEN;
    end else if (snap.hdr_sum != ipv4rhf_pkg::SUM_GOOD) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_CHECKSUM;
    end else if (snap.total_len > snap.pkt_len) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_TOTAL_LEN;
    end else if (snap.dst_addr != local_addr && snap.dst_addr != ipv4rhf_pkg::BROADCAST_ADDR) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_ADDRESS;
    end else if (snap.protocol == ipv4rhf_pkg::PROTOCOL_ICMP) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_ICMP;
    end else if (snap.protocol == ipv4rhf_pkg::PROTOCOL_UDP) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_UDP;
    end else if (snap.protocol == ipv4rhf_pkg::PROTOCOL_TCP) begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_TCP;
    end else begin
      verdict_nxt = ipv4rhf_pkg::VERDICT_UNKNOWN;
    end

    if (load) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= verdict_nxt;
      src_r     <= snap.src_addr;
      dst_r     <= snap.dst_addr;
      hbytes_r  <= hbytes_nxt;
      payload_r <= payload_nxt;
    end
  end

  assign res_valid       = valid_r;
  assign res_verdict     = verdict_r;
  assign res_src         = src_r;
  assign res_dst         = dst_r;
  assign res_hdr_bytes   = hbytes_r;
  assign res_payload_len = payload_r;

endmodule

// ===== src/ipv4_receive_header_filter.sv =====
// IPv4 receive header filter. Takes a packet one byte per input transaction
// (tlast on the final byte) and returns one result transaction per packet:
// the verdict in out_tuser (route to icmp/udp/tcp, unknown protocol, or the
// first failed check among short, version, header length, checksum, total
// length and destination address) plus source and destination address,
// header size and payload length in out_tdata. One byte is accepted every
// clock while in_tready is high; the header checksum is folded one 16-bit
// word per two bytes as the bytes stream in. The edge that accepts the last
// byte loads the packet snapshot register; once the output register is free,
// the check logic moves it into the output register. in_tready only drops
// while a finished snapshot and an unaccepted result are both waiting.
// The local address is written through the cfg channel, which is always
// ready; write it while no packet is in flight.
module ipv4_receive_header_filter (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write: local address, first header byte most significant
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // packet byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] packet_byte
  input  logic        in_tlast,   // end_of_packet
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [31:0] source_ip, [63:32] dest_ip,
                                  // [69:64] header_bytes, [85:70] payload_length
  output logic [3:0]  out_tuser   // [3:0] verdict
);

  logic [31:0]            local_addr_r;
  logic                   snap_valid;
  logic                   snap_ready;
  ipv4rhf_pkg::hdr_snap_t snap;
  ipv4rhf_pkg::verdict_t  res_verdict;
  logic [31:0]            res_src;
  logic [31:0]            res_dst;
  logic [5:0]             res_hdr_bytes;
  logic [15:0]            res_payload_len;

  // local address register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      local_addr_r <= cfg_data;
    end
  end

  ipv4rhf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .pkt_byte   (in_tdata),
    .pkt_last   (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  ipv4rhf_verdict u_verdict (
    .clk             (clk),
    .rst_n           (rst_n),
    .local_addr      (local_addr_r),
    .snap_valid      (snap_valid),
    .snap_ready      (snap_ready),
    .snap            (snap),
    .res_valid       (out_tvalid),
    .res_ready       (out_tready),
    .res_verdict     (res_verdict),
    .res_src         (res_src),
    .res_dst         (res_dst),
    .res_hdr_bytes   (res_hdr_bytes),
    .res_payload_len (res_payload_len)
  );

  // pack result fields
  assign out_tuser = res_verdict;
  assign out_tdata = {2'b00, res_payload_len, res_hdr_bytes, res_dst, res_src};

endmodule

// ===== src/ipv4rhf_checker.sv =====
module ipv4rhf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // verdict codes stay in the defined range
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= 4'd9)
    else $error("verdict code out of range");

  // a routed packet must carry a legal header size
  a_routed_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser <= 4'd3 |-> out_tdata[69:64] >= 6'd20 && out_tdata[65:64] == 2'b00)
    else $error("routed packet with illegal header size");

  // input can only stall while a result is stuck downstream
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind ipv4_receive_header_filter ipv4rhf_checker u_ipv4rhf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
